[src/iev_pkg.sv]
// Shared constants, types and helpers for the infix expression evaluator.
// No dependencies; the top level, the arithmetic unit and the checker import this package.
package iev_pkg;

    localparam int NUM_DEPTH = 32;
    localparam int OP_DEPTH  = 4;
    localparam int NUM_AW    = $clog2(NUM_DEPTH);
    localparam int NUM_CW    = $clog2(NUM_DEPTH + 1);
    localparam int OP_AW     = $clog2(OP_DEPTH);
    localparam int OP_CW     = $clog2(OP_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_code_t;

    typedef struct packed {
        logic     start;
        op_code_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic zero_div;
    } alu_rsp_t;

    // Multiply and divide bind tighter than add and subtract.
    function automatic logic rank_high(input op_code_t op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

endpackage

[src/infix_expression_evaluator.sv]
// Top level of the infix expression evaluator: sequencer, operator stack and number stack.
// Depends on iev_pkg, iev_ram and iev_alu.
//
//  Channel  | Ports                                   | Direction
//  ---------+-----------------------------------------+----------
//  input    | s_valid s_ready s_ch s_last             | in
//  result   | m_valid m_ready m_value m_div_by_zero   | out
//           | m_malformed                             |
//
// A digit or an ignored character is taken in S_IDLE alone. An operator passes through
// S_OP_CHECK plus one reduction per operator it pops; a reduction runs S_RED_B, S_RED_A,
// S_EXEC and S_EXEC_WAIT, and a divide waits in S_EXEC_WAIT on the bit-serial divider
// in the shared unit. The final character adds its reductions, then S_FIN_READ and
// S_FIN_OUT to read the bottom of the number stack and load the result register.
// Reset is synchronous and active low and empties both stacks; no clearing pass.
// The result sits in an output register, so a new expression may start while a
// result waits; the block stalls only if a second result is ready before then.
module infix_expression_evaluator
    import iev_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_value,
    output logic        m_div_by_zero,
    output logic        m_malformed
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_OP_CHECK,
        S_FIN_CHECK,
        S_RED_B,
        S_RED_A,
        S_EXEC,
        S_EXEC_WAIT,
        S_FIN_READ,
        S_FIN_OUT
    } state_t;

    state_t            state_reg;
    logic [NUM_CW-1:0] numcnt_reg;
    logic [OP_CW-1:0]  opcnt_reg;
    logic [1:0]        opstk_reg [OP_DEPTH];
    logic [31:0]       pend_reg;
    logic              in_number_reg;
    logic              dz_seen_reg;
    logic              err_seen_reg;
    op_code_t          new_op_reg;
    op_code_t          red_op_reg;
    logic              last_reg;
    logic              ret_fin_reg;
    logic              under_b_reg;
    logic              under_a_reg;
    logic [31:0]       b_reg;
    logic [31:0]       fin_val_reg;
    logic              m_valid_reg;
    logic [31:0]       m_value_reg;
    logic              m_dz_reg;
    logic              m_err_reg;

    // Input decode for the transaction in S_IDLE.
    logic        accept;
    logic        is_digit;
    logic [31:0] digit_val;
    logic [31:0] pend_val;
    logic        in_num;
    logic        flush;
    logic        is_op;
    op_code_t    in_code;

    assign accept    = s_valid && s_ready;
    assign is_digit  = (s_ch >= CH_ZERO) && (s_ch <= CH_NINE);
    assign digit_val = {28'd0, s_ch[3:0]};
    assign pend_val  = is_digit ?
        ({pend_reg[28:0], 3'b000} + {pend_reg[30:0], 1'b0} + digit_val) : pend_reg;
    assign in_num    = is_digit || in_number_reg;
    assign flush     = !is_digit || s_last;

    always_comb begin
        is_op   = 1'b1;
        in_code = OP_ADD;
        case (s_ch)
            CH_PLUS:  in_code = OP_ADD;
            CH_MINUS: in_code = OP_SUB;
            CH_STAR:  in_code = OP_MUL;
            CH_SLASH: in_code = OP_DIV;
            default:  is_op = 1'b0;
        endcase
    end

    // Stack pointers.
    logic [NUM_CW-1:0] num_dec;
    logic [OP_CW-1:0]  op_dec;
    logic              num_full;
    logic              op_full;
    op_code_t          op_top;

    assign num_dec  = numcnt_reg - NUM_CW'(1);
    assign op_dec   = opcnt_reg - OP_CW'(1);
    assign num_full = (numcnt_reg == NUM_CW'(NUM_DEPTH));
    assign op_full  = (opcnt_reg == OP_CW'(OP_DEPTH));
    assign op_top   = op_code_t'(opstk_reg[op_dec[OP_AW-1:0]]);

    // Number stack memory.
    logic              ram_we;
    logic [31:0]       ram_wdata;
    logic [NUM_AW-1:0] ram_raddr;
    logic [31:0]       ram_rdata;

    // Shared arithmetic unit.
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    logic [31:0] alu_a;
    logic [31:0] alu_result;

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = alu_result;
        case (state_reg)
            S_IDLE: begin
                ram_we    = accept && flush && in_num && !num_full;
                ram_wdata = pend_val;
            end
            S_EXEC_WAIT: begin
                ram_we = alu_rsp.done && !num_full;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // The pop address is always the entry just below the count; the final
    // readout takes the bottom entry.
    assign ram_raddr = (state_reg == S_FIN_CHECK) ? NUM_AW'(0) : num_dec[NUM_AW-1:0];

    assign alu_req.start = (state_reg == S_EXEC);
    assign alu_req.op    = red_op_reg;
    assign alu_a         = under_a_reg ? 32'd0 : ram_rdata;

    iev_ram #(
        .WIDTH(32),
        .DEPTH(NUM_DEPTH)
    ) u_num_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (numcnt_reg[NUM_AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    iev_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (alu_a),
        .b       (b_reg),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            numcnt_reg    <= '0;
            opcnt_reg     <= '0;
            pend_reg      <= 32'd0;
            in_number_reg <= 1'b0;
            dz_seen_reg   <= 1'b0;
            err_seen_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // S_FIN_OUT decides the output valid on its own when it hands over.
            if (m_valid_reg && m_ready && (state_reg != S_FIN_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        // A non-digit, or the final character, ends any pending number.
                        if (flush) begin
                            if (in_num) begin
                                if (num_full) begin
                                    err_seen_reg <= 1'b1;
                                end else begin
                                    numcnt_reg <= numcnt_reg + NUM_CW'(1);
                                end
                            end
                            pend_reg      <= 32'd0;
                            in_number_reg <= 1'b0;
                        end else begin
                            pend_reg      <= pend_val;
                            in_number_reg <= 1'b1;
                        end
                        new_op_reg <= in_code;
                        last_reg   <= s_last;
                        if (is_op) begin
                            state_reg <= S_OP_CHECK;
                        end else if (s_last) begin
                            state_reg <= S_FIN_CHECK;
                        end
                    end
                end
                S_OP_CHECK: begin
                    // Reduce while the top operator binds at least as tightly.
                    if ((opcnt_reg != '0) &&
                        (rank_high(op_top) || !rank_high(new_op_reg))) begin
                        ret_fin_reg <= 1'b0;
                        state_reg   <= S_RED_B;
                    end else begin
                        if (op_full) begin
                            err_seen_reg <= 1'b1;
                        end else begin
                            opstk_reg[opcnt_reg[OP_AW-1:0]] <= new_op_reg;
                            opcnt_reg <= opcnt_reg + OP_CW'(1);
                        end
                        state_reg <= last_reg ? S_FIN_CHECK : S_IDLE;
                    end
                end
                S_FIN_CHECK: begin
                    if (opcnt_reg != '0) begin
                        ret_fin_reg <= 1'b1;
                        state_reg   <= S_RED_B;
                    end else begin
                        state_reg <= S_FIN_READ;
                    end
                end
                S_RED_B: begin
                    // Pop the operator and issue the read of the right operand.
                    red_op_reg <= op_top;
                    opcnt_reg  <= op_dec;
                    if (numcnt_reg == '0) begin
                        under_b_reg  <= 1'b1;
                        err_seen_reg <= 1'b1;
                    end else begin
                        under_b_reg <= 1'b0;
                        numcnt_reg  <= num_dec;
                    end
                    state_reg <= S_RED_A;
                end
                S_RED_A: begin
                    // Capture the right operand and issue the read of the left one.
                    b_reg <= under_b_reg ? 32'd0 : ram_rdata;
                    if (numcnt_reg == '0) begin
                        under_a_reg  <= 1'b1;
                        err_seen_reg <= 1'b1;
                    end else begin
                        under_a_reg <= 1'b0;
                        numcnt_reg  <= num_dec;
                    end
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    state_reg <= S_EXEC_WAIT;
                end
                S_EXEC_WAIT: begin
                    if (alu_rsp.done) begin
                        if (alu_rsp.zero_div) begin
                            dz_seen_reg <= 1'b1;
                        end
                        if (num_full) begin
                            err_seen_reg <= 1'b1;
                        end else begin
                            numcnt_reg <= numcnt_reg + NUM_CW'(1);
                        end
                        state_reg <= ret_fin_reg ? S_FIN_CHECK : S_OP_CHECK;
                    end
                end
                S_FIN_READ: begin
                    fin_val_reg <= (numcnt_reg == '0) ? 32'd0 : ram_rdata;
                    state_reg   <= S_FIN_OUT;
                end
                S_FIN_OUT: begin
                    // Hand the result to the output register and start afresh.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_value_reg   <= fin_val_reg;
                        m_dz_reg      <= dz_seen_reg;
                        m_err_reg     <= err_seen_reg;
                        numcnt_reg    <= '0;
                        opcnt_reg     <= '0;
                        pend_reg      <= 32'd0;
                        in_number_reg <= 1'b0;
                        dz_seen_reg   <= 1'b0;
                        err_seen_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_value       = m_value_reg;
    assign m_div_by_zero = m_dz_reg;
    assign m_malformed   = m_err_reg;

endmodule

[src/iev_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module iev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/iev_alu.sv]
// Shared arithmetic unit: add, subtract, multiply, and a bit-serial signed divider.
// Depends on iev_pkg for the operation codes and the request/response structs.
module iev_alu
    import iev_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  alu_req_t    req,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output alu_rsp_t    rsp,
    output logic [31:0] result
);

    typedef enum logic [1:0] {A_IDLE, A_DIV, A_FIX} alu_state_t;

    alu_state_t  state_reg;
    logic [31:0] dvd_reg;
    logic [31:0] dvs_reg;
    logic [31:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic        neg_reg;
    logic        done_reg;
    logic        dz_reg;
    logic [31:0] res_reg;

    logic [63:0] prod;
    logic [32:0] rem_shift;
    logic [32:0] rem_diff;
    logic [31:0] abs_a;
    logic [31:0] abs_b;

    assign prod      = a * b;
    assign abs_a     = a[31] ? (32'd0 - a) : a;
    assign abs_b     = b[31] ? (32'd0 - b) : b;
    assign rem_shift = {rem_reg, dvd_reg[31]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            dz_reg    <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            dz_reg   <= 1'b0;
            case (state_reg)
                A_IDLE: begin
                    if (req.start) begin
                        case (req.op)
                            OP_ADD: begin
                                res_reg  <= a + b;
                                done_reg <= 1'b1;
                            end
                            OP_SUB: begin
                                res_reg  <= a - b;
                                done_reg <= 1'b1;
                            end
                            OP_MUL: begin
                                res_reg  <= prod[31:0];
                                done_reg <= 1'b1;
                            end
                            default: begin
                                if (b == 32'd0) begin
                                    res_reg  <= 32'd0;
                                    done_reg <= 1'b1;
                                    dz_reg   <= 1'b1;
                                end else begin
                                    dvd_reg   <= abs_a;
                                    dvs_reg   <= abs_b;
                                    rem_reg   <= 32'd0;
                                    cnt_reg   <= 5'd31;
                                    neg_reg   <= a[31] ^ b[31];
                                    state_reg <= A_DIV;
                                end
                            end
                        endcase
                    end
                end
                A_DIV: begin
                    // One quotient bit per cycle; quotient bits shift into dvd_reg.
                    if (!rem_diff[32]) begin
                        rem_reg <= rem_diff[31:0];
                        dvd_reg <= {dvd_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= rem_shift[31:0];
                        dvd_reg <= {dvd_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        state_reg <= A_FIX;
                    end
                end
                A_FIX: begin
                    res_reg   <= neg_reg ? (32'd0 - dvd_reg) : dvd_reg;
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.zero_div = dz_reg;
    assign result       = res_reg;

endmodule

[src/iev_checker.sv]
// Port-level checks for the infix expression evaluator, bound to the top level.
// Depends on iev_pkg for the character codes and on the top level's ports.
module iev_checker
    import iev_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_ch,
    input logic        s_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_value,
    input logic        m_div_by_zero,
    input logic        m_malformed
);

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value)
            && $stable(m_div_by_zero) && $stable(m_malformed))
        else $error("stalled result changed");

    // A character that is not the last never produces a result by itself.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last && !m_valid |=> !m_valid)
        else $error("result without a final character");

    // The final character always starts an evaluation that holds off input.
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input accepted right after the final character");

    // An operator character always holds off input in the cycle after it is taken.
    a_busy_after_op: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_ch == CH_PLUS || s_ch == CH_MINUS
            || s_ch == CH_STAR || s_ch == CH_SLASH) |=> !s_ready)
        else $error("input accepted right after an operator");

endmodule

bind infix_expression_evaluator iev_checker u_iev_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_ch          (s_ch),
    .s_last        (s_last),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_value       (m_value),
    .m_div_by_zero (m_div_by_zero),
    .m_malformed   (m_malformed)
);
